// ----- rtl/crc16fr_pkg.sv -----
// Constants and CRC update function for the CRC-16 frame receiver.
package crc16fr_pkg;

  localparam int unsigned PAYLOAD_LEN = 12;
  localparam int unsigned POS_W = 4;
  localparam int unsigned IDX_W = $clog2(PAYLOAD_LEN);

  localparam logic [POS_W-1:0] POS_HUNT     = 4'd0;
  localparam logic [POS_W-1:0] POS_SECOND   = 4'd1;
  localparam logic [POS_W-1:0] POS_PAYLOAD  = 4'd2;
  localparam logic [POS_W-1:0] POS_CRC_LOW  = 4'd14;
  localparam logic [POS_W-1:0] POS_CRC_HIGH = 4'd15;

  localparam logic [15:0] CRC_START = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'h8408;

  localparam logic [7:0] HEADER_FIRST_RESET  = 8'h55;
  localparam logic [7:0] HEADER_SECOND_RESET = 8'h00;

  localparam logic [0:0] REG_HEADER_FIRST  = 1'b0;
  localparam logic [0:0] REG_HEADER_SECOND = 1'b1;

  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ----- rtl/crc16_frame_receiver.sv -----
// CRC-16 checked frame receiver: header hunt, payload capture, CRC check, result register.
//
// Usage:
//   Input channel: rx_byte with in_valid / in_stall, one received byte per transaction.
//   Output channel: first_word, second_word, third_word, check_ok with out_valid / out_stall,
//   one transaction per complete 16-byte frame (two header bytes, 12 payload bytes,
//   little-endian CRC-16 over the first 14 bytes, reflected poly 0x8408, start 0xFFFF).
//   Configuration: cfg_write, cfg_index, cfg_data set the two header bytes; write only while idle.
// Throughput: one byte per cycle while in_stall is low; the CRC update for a byte is combinational
//   logic between the byte input and the running CRC register.
// Result: registered, valid in the cycle after the last CRC byte is accepted.
// Reset: hunt for the header, running CRC at 0xFFFF, header bytes 0x55 and 0x00, no result.
// Stall: a waiting result does not block bytes; in_stall rises only when the next byte
//   would close a frame while the previous result is still stalled.
module crc16_frame_receiver (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [0:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] first_word,
  output logic [31:0] second_word,
  output logic [31:0] third_word,
  output logic        check_ok
);
  import crc16fr_pkg::*;

  logic [7:0]       header_first;
  logic [7:0]       header_second;
  logic [POS_W-1:0] byte_position;
  logic [POS_W-1:0] byte_position_next;
  logic [15:0]      running_crc;
  logic [15:0]      running_crc_next;
  logic [7:0]       payload_store [PAYLOAD_LEN];
  logic [7:0]       crc_low_byte;
  logic [15:0]      crc_in;
  logic [15:0]      crc_out;
  logic [POS_W-1:0] store_pos;
  logic             in_accept;
  logic             out_accept;
  logic             frame_done;
  logic             in_payload;

  assign in_stall   = out_valid && out_stall && (byte_position == POS_CRC_HIGH);
  assign in_accept  = in_valid && !in_stall;
  assign out_accept = out_valid && !out_stall;
  assign frame_done = in_accept && (byte_position == POS_CRC_HIGH);
  assign in_payload = (byte_position >= POS_PAYLOAD) && (byte_position < POS_CRC_LOW);
  assign store_pos  = byte_position - POS_PAYLOAD;

  assign crc_in  = (byte_position == POS_HUNT) ? CRC_START : running_crc;
  assign crc_out = crc_update(crc_in, rx_byte);

  always_comb begin
    byte_position_next = byte_position;
    running_crc_next   = running_crc;
    priority if (byte_position == POS_HUNT) begin
      if (rx_byte == header_first) begin
        byte_position_next = POS_SECOND;
        running_crc_next   = crc_out;
      end
    end else if (byte_position == POS_SECOND) begin
      if (rx_byte == header_second) begin
        byte_position_next = POS_PAYLOAD;
        running_crc_next   = crc_out;
      end else begin
        byte_position_next = POS_HUNT;
        running_crc_next   = CRC_START;
      end
    end else if (in_payload) begin
      byte_position_next = byte_position + 4'd1;
      running_crc_next   = crc_out;
    end else if (byte_position == POS_CRC_LOW) begin
      byte_position_next = POS_CRC_HIGH;
    end else begin
      byte_position_next = POS_HUNT;
      running_crc_next   = CRC_START;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_first  <= HEADER_FIRST_RESET;
      header_second <= HEADER_SECOND_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_HEADER_FIRST:  header_first  <= cfg_data;
        REG_HEADER_SECOND: header_second <= cfg_data;
        default:           header_first  <= header_first;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= POS_HUNT;
      running_crc   <= CRC_START;
    end else if (in_accept) begin
      byte_position <= byte_position_next;
      running_crc   <= running_crc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && in_payload) begin
      payload_store[store_pos[IDX_W-1:0]] <= rx_byte;
    end
    if (in_accept && (byte_position == POS_CRC_LOW)) begin
      crc_low_byte <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (frame_done) begin
      out_valid <= 1'b1;
    end else if (out_accept) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_done) begin
      first_word  <= {payload_store[3], payload_store[2], payload_store[1], payload_store[0]};
      second_word <= {payload_store[7], payload_store[6], payload_store[5], payload_store[4]};
      third_word  <= {payload_store[11], payload_store[10], payload_store[9], payload_store[8]};
      check_ok    <= ({rx_byte, crc_low_byte} == running_crc);
    end
  end

  a_stall_only_at_frame_end: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (byte_position == POS_CRC_HIGH) && out_valid)
    else $error("input stalled away from frame end");

  a_result_after_frame: assert property (@(posedge clk) disable iff (rst)
    frame_done |=> out_valid && (byte_position == POS_HUNT) && (running_crc == CRC_START))
    else $error("frame end did not produce a result or restart the hunt");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(byte_position) == POS_CRC_HIGH)
    else $error("result raised without a completed frame");

  a_bad_second_header: assert property (@(posedge clk) disable iff (rst)
    in_accept && (byte_position == POS_SECOND) && (rx_byte != header_second)
    |=> (byte_position == POS_HUNT) && (running_crc == CRC_START))
    else $error("wrong second header byte did not restart the hunt");

endmodule
